// ===== rtl/core/overlay_fade_envelope_assert.svh =====
// assertion macros for the overlay fade envelope
`ifndef OVERLAY_FADE_ENVELOPE_ASSERT_SVH
`define OVERLAY_FADE_ENVELOPE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define OFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ofe_pkg.sv =====
// shared types, register indexes and reset values for the overlay fade envelope
package ofe_pkg;

   localparam int unsigned LevelWidth = 16;
   localparam int unsigned DtWidth    = 10;
   localparam int unsigned CsrIdxWidth = 8;

   localparam logic [LevelWidth-1:0] LevelMax = 16'hFFFF;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_RISE_RATE   = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_FALL_RATE   = 8'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SETTLE_TIME = 8'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLD_LIMIT  = 8'd3;

   // configuration reset values
   localparam logic [15:0] RiseRateReset   = 16'd109;
   localparam logic [15:0] FallRateReset   = 16'd328;
   localparam logic [15:0] SettleTimeReset = 16'd400;
   localparam logic [15:0] HoldLimitReset  = 16'd5000;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_FORCE = 2'd1,
      OP_RESET = 2'd2
   } ofe_op_type;

   typedef struct packed {
      logic [15:0] rise_rate;
      logic [15:0] fall_rate;
      logic [15:0] settle_time;
      logic [15:0] hold_limit;
   } ofe_cfg_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [DtWidth-1:0]    elapsed_ms;
      logic                  want_visible;
      logic                  loading_now;
      logic                  hud_now;
      logic                  screen_fading;
      logic [LevelWidth-1:0] force_level;
   } ofe_item_type;

   typedef struct packed {
      logic [LevelWidth-1:0] fade_level;
      logic [15:0]           hold_left;
      logic [15:0]           settle_left;
      logic                  was_loading;
      logic                  was_hud;
   } ofe_state_type;

endpackage

// ===== rtl/core/ofe_step.sv =====
// next-state logic of the fade envelope for one request
module ofe_step (
   input  ofe_pkg::ofe_cfg_type   cfg,
   input  ofe_pkg::ofe_item_type  item,
   input  ofe_pkg::ofe_state_type cur,
   output ofe_pkg::ofe_state_type nxt
);
   import ofe_pkg::*;

   logic        arm;
   logic [15:0] hold_arm;
   logic [15:0] settle_arm;
   logic [15:0] dt16;
   logic [15:0] hold_run;
   logic [15:0] settle_run;
   logic        rising;
   logic [15:0] rate;
   logic [25:0] step;
   logic [26:0] sum;
   logic [LevelWidth-1:0] tick_level;

   assign dt16 = {{(16-DtWidth){1'b0}}, item.elapsed_ms};

   // arming edges: loading closes or hud opens
   assign arm = (cur.was_loading & ~item.loading_now) | (~cur.was_hud & item.hud_now);
   assign hold_arm   = arm ? cfg.hold_limit  : cur.hold_left;
   assign settle_arm = arm ? cfg.settle_time : cur.settle_left;

   always_comb begin
      hold_run   = hold_arm;
      settle_run = settle_arm;
      if (hold_arm != 16'd0) begin
         hold_run = (dt16 >= hold_arm) ? 16'd0 : hold_arm - dt16;
         if (item.screen_fading) begin
            settle_run = cfg.settle_time;
         end else begin
            settle_run = (dt16 >= settle_arm) ? 16'd0 : settle_arm - dt16;
         end
         if (settle_run == 16'd0) begin
            hold_run = 16'd0;
         end
      end
   end

   // one shared multiplier for the ramp step
   assign rising = item.want_visible && (hold_run == 16'd0);
   assign rate   = rising ? cfg.rise_rate : cfg.fall_rate;
   assign step   = {16'd0, item.elapsed_ms} * {10'd0, rate};
   assign sum    = {1'b0, step} + {11'd0, cur.fade_level};

   always_comb begin
      if (rising) begin
         tick_level = (sum > {11'd0, LevelMax}) ? LevelMax : sum[LevelWidth-1:0];
      end else begin
         tick_level = (step >= {10'd0, cur.fade_level}) ? '0
                    : cur.fade_level - step[LevelWidth-1:0];
      end
   end

   always_comb begin
      nxt = cur;
      case (ofe_op_type'(item.opcode))
         OP_TICK: begin
            nxt.fade_level  = tick_level;
            nxt.hold_left   = hold_run;
            nxt.settle_left = settle_run;
            nxt.was_loading = item.loading_now;
            nxt.was_hud     = item.hud_now;
         end
         OP_FORCE: begin
            nxt.fade_level = item.force_level;
            nxt.hold_left  = 16'd0;
         end
         OP_RESET: begin
            nxt.fade_level  = '0;
            nxt.hold_left   = 16'd0;
            nxt.settle_left = 16'd0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== rtl/core/overlay_fade_envelope.sv =====
// top level of the overlay fade envelope: request register, step logic, response register
//
// usage
//   req_* carries one request per accepted valid/ready handshake: an opcode (tick,
//   force level, reset envelope), the elapsed milliseconds and the four screen flags
//   plus a force level. rsp_* returns exactly one response, the fade level after the
//   request, in request order.
//   csr_we/csr_index/csr_wdata write the four rate and timer registers with no wait
//   and no read-back; unknown indexes are dropped. write only while idle.
// flow and throughput
//   a request is held in the request register, the step logic then writes the response
//   register, and the response leaves from there once rsp_ready is high. one request
//   per cycle is sustained while rsp_ready stays high; the single 10x16 ramp
//   multiplier and its saturating add sit between the two registers.
// reset
//   synchronous, active high: both stages empty, envelope state zero, registers back
//   to their defaults.
// stall
//   while rsp_ready is low the response holds; one more request is taken into the
//   request register, then req_ready drops until the response leaves.
module overlay_fade_envelope (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_opcode,
   input  logic [ofe_pkg::DtWidth-1:0]      req_elapsed_ms,
   input  logic                             req_want_visible,
   input  logic                             req_loading_now,
   input  logic                             req_hud_now,
   input  logic                             req_screen_fading,
   input  logic [ofe_pkg::LevelWidth-1:0]   req_force_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ofe_pkg::LevelWidth-1:0]   rsp_level,
   input  logic                             csr_we,
   input  logic [ofe_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [15:0]                      csr_wdata
);
   import ofe_pkg::*;

   // configuration registers
   ofe_cfg_type   cfg_ff, cfg_in;
   // request stage
   logic          req_valid_ff, req_valid_in;
   ofe_item_type  item_ff, item_in;
   // envelope state
   ofe_state_type state_ff, state_in;
   // response stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LevelWidth-1:0] level_ff, level_in;

   ofe_state_type state_next;
   logic          advance;
   logic          take;

   // request moves on when the response slot is free or being emptied
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;

   ofe_step u_step (
      .cfg (cfg_ff),
      .item(item_ff),
      .cur (state_ff),
      .nxt (state_next)
   );

   // csr write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RISE_RATE:   cfg_in.rise_rate   = csr_wdata;
            CSR_FALL_RATE:   cfg_in.fall_rate   = csr_wdata;
            CSR_SETTLE_TIME: cfg_in.settle_time = csr_wdata;
            CSR_HOLD_LIMIT:  cfg_in.hold_limit  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.opcode        = req_opcode;
         item_in.elapsed_ms    = req_elapsed_ms;
         item_in.want_visible  = req_want_visible;
         item_in.loading_now   = req_loading_now;
         item_in.hud_now       = req_hud_now;
         item_in.screen_fading = req_screen_fading;
         item_in.force_level   = req_force_level;
      end
   end

   assign req_valid_in = take || (req_valid_ff && !advance);
   assign state_in     = advance ? state_next : state_ff;
   assign level_in     = advance ? state_next.fade_level : level_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_rate   <= RiseRateReset;
         cfg_ff.fall_rate   <= FallRateReset;
         cfg_ff.settle_time <= SettleTimeReset;
         cfg_ff.hold_limit  <= HoldLimitReset;
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff           <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      level_ff <= level_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = level_ff;

   // checks on the envelope and the two-stage flow
   `include "overlay_fade_envelope_assert.svh"

   `OFE_ASSERT_NOW(a_hold_needs_settle, clock, reset, state_ff.hold_left != 16'd0, state_ff.settle_left != 16'd0, "hold active with settle timer at zero")
   `OFE_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready, req_valid_ff && rsp_valid_ff && !rsp_ready, "request refused with a free stage")
   `OFE_ASSERT_NEXT(a_reset_op_zero, clock, reset, advance && item_ff.opcode == OP_RESET, rsp_valid && rsp_level == '0, "reset request did not report level zero")
   `OFE_ASSERT_NEXT(a_force_op_level, clock, reset, advance && item_ff.opcode == OP_FORCE, rsp_valid && state_ff.hold_left == 16'd0, "force request left a hold running")

endmodule

// ===== sim/tb_overlay_fade_envelope.sv =====
// testbench for the overlay fade envelope: random and directed requests checked against a predictor
`timescale 1ns / 1ps

module tb_overlay_fade_envelope;
   import ofe_pkg::*;

   // opcode that the block must treat as a no-op
   localparam logic [1:0] OpUnused = 2'd3;
   // hard stop for the whole run
   localparam int unsigned RunLimitNs = 5_000_000;

   // one queued request plus a flag that holds it back until the block has drained
   typedef struct packed {
      logic         hold_off;
      ofe_item_type body;
   } pending_req_type;

   // receiver stall patterns
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_CHOKE,
      RX_PERIODIC
   } rx_pattern_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_opcode = '0;
   logic [DtWidth-1:0]      req_elapsed_ms = '0;
   logic                    req_want_visible = 1'b0;
   logic                    req_loading_now = 1'b0;
   logic                    req_hud_now = 1'b0;
   logic                    req_screen_fading = 1'b0;
   logic [LevelWidth-1:0]   req_force_level = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [LevelWidth-1:0]   rsp_level;
   logic                    csr_we = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [15:0]             csr_wdata = '0;

   // requests waiting to be driven, levels waiting to come back
   pending_req_type         req_backlog[$];
   logic [LevelWidth-1:0]   expected_levels[$];
   int                      levels_in_flight = 0;
   int                      mismatch_count = 0;

   // predictor copy of the envelope state and the register file
   ofe_cfg_type             cfg_shadow;
   logic [LevelWidth-1:0]   env_level;
   logic [15:0]             env_hold;
   logic [15:0]             env_settle;
   logic                    env_was_loading;
   logic                    env_was_hud;

   // sender burst/gap and receiver pattern bookkeeping
   int                      burst_left = 0;
   int                      gap_left = 0;
   rx_pattern_type          rx_mode = RX_OPEN;
   int                      rx_left = 0;

   overlay_fade_envelope dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_elapsed_ms    (req_elapsed_ms),
      .req_want_visible  (req_want_visible),
      .req_loading_now   (req_loading_now),
      .req_hud_now       (req_hud_now),
      .req_screen_fading (req_screen_fading),
      .req_force_level   (req_force_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_level         (rsp_level),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timer subtract that stops at zero
   function automatic logic [15:0] drain_ms(input logic [15:0] left, input logic [15:0] dt);
      return (dt >= left) ? 16'd0 : left - dt;
   endfunction

   // apply one request to the predicted envelope and return the level it reports
   function automatic logic [LevelWidth-1:0] advance_envelope(input ofe_item_type r);
      logic [26:0] ramp;
      logic [15:0] dt;
      dt = {6'd0, r.elapsed_ms};
      case (r.opcode)
         OP_TICK: begin
            // a loading screen closing or the hud opening arms both timers
            if ((env_was_loading && !r.loading_now) || (!env_was_hud && r.hud_now)) begin
               env_hold = cfg_shadow.hold_limit;
               env_settle = cfg_shadow.settle_time;
            end
            env_was_loading = r.loading_now;
            env_was_hud = r.hud_now;
            // the same tick that armed the hold already counts it down
            if (env_hold != 16'd0) begin
               env_hold = drain_ms(env_hold, dt);
               env_settle = r.screen_fading ? cfg_shadow.settle_time
                                            : drain_ms(env_settle, dt);
               if (env_settle == 16'd0)
                  env_hold = 16'd0;
            end
            if (r.want_visible && env_hold == 16'd0) begin
               ramp = 27'(dt) * 27'(cfg_shadow.rise_rate) + 27'(env_level);
               env_level = (ramp > 27'(LevelMax)) ? LevelMax : ramp[15:0];
            end else begin
               ramp = 27'(dt) * 27'(cfg_shadow.fall_rate);
               env_level = (ramp >= 27'(env_level)) ? '0 : env_level - ramp[15:0];
            end
         end
         OP_FORCE: begin
            // settle timer and edge history survive a force
            env_level = r.force_level;
            env_hold = 16'd0;
         end
         OP_RESET: begin
            env_level = '0;
            env_hold = 16'd0;
            env_settle = 16'd0;
         end
         default: ;
      endcase
      return env_level;
   endfunction

   task automatic queue_req(input logic [1:0] op, input logic [9:0] dt, input logic vis,
                            input logic load, input logic hud, input logic fade,
                            input logic [15:0] lvl, input logic hold_off);
      pending_req_type p;
      p.hold_off = hold_off;
      p.body.opcode = op;
      p.body.elapsed_ms = dt;
      p.body.want_visible = vis;
      p.body.loading_now = load;
      p.body.hud_now = hud;
      p.body.screen_fading = fade;
      p.body.force_level = lvl;
      req_backlog.push_back(p);
   endtask

   // idle means nothing queued, nothing offered and no level outstanding;
   // checked on the falling edge so every clocked update has settled
   task automatic wait_for_idle();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || levels_in_flight != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RISE_RATE:   cfg_shadow.rise_rate = data;
         CSR_FALL_RATE:   cfg_shadow.fall_rate = data;
         CSR_SETTLE_TIME: cfg_shadow.settle_time = data;
         CSR_HOLD_LIMIT:  cfg_shadow.hold_limit = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_envelope_config(input logic [15:0] rise, input logic [15:0] fall,
                                      input logic [15:0] settle, input logic [15:0] hold);
      wait_for_idle();
      write_csr(CSR_RISE_RATE, rise);
      write_csr(CSR_FALL_RATE, fall);
      write_csr(CSR_SETTLE_TIME, settle);
      write_csr(CSR_HOLD_LIMIT, hold);
      // a write to an unmapped index must change nothing
      write_csr(CsrIdxWidth'($urandom_range(int'(CSR_HOLD_LIMIT) + 1, (1 << CsrIdxWidth) - 1)),
                16'($urandom_range(0, 65535)));
   endtask

   // flags stay put over segments, but for the fade flag that flips now and then, so that
   // edges, holds and settle countdowns play out; a few requests carry scrambled flags as noise
   task automatic queue_random_reqs(input int count);
      int seg_left;
      int dt_cap;
      int pick;
      logic vis, load, hud, fade;
      logic [1:0] op;
      logic [15:0] lvl;
      logic [9:0] dt;
      seg_left = 0;
      dt_cap = 20;
      vis = 1'b0;
      load = 1'b0;
      hud = 1'b0;
      fade = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(2, 40);
            vis = ($urandom_range(0, 3) != 0);
            load = ($urandom_range(0, 2) == 0);
            hud = 1'($urandom_range(0, 1));
            fade = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
               0: dt_cap = 3;
               1: dt_cap = 25;
               2: dt_cap = 80;
               default: dt_cap = 1023;
            endcase
         end
         seg_left--;
         if ($urandom_range(0, 7) == 0)
            fade = !fade;
         pick = $urandom_range(0, 99);
         if (pick < 86)
            op = OP_TICK;
         else if (pick < 92)
            op = OP_FORCE;
         else if (pick < 96)
            op = OP_RESET;
         else
            op = OpUnused;
         dt = 10'($urandom_range(0, dt_cap));
         case ($urandom_range(0, 5))
            0: lvl = '0;
            1: lvl = LevelMax;
            default: lvl = 16'($urandom_range(0, 65535));
         endcase
         if ($urandom_range(0, 9) == 0)
            queue_req(op, dt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), lvl,
                      n == count / 2);
         else
            // midway through every batch the sender waits for a full drain
            queue_req(op, dt, vis, load, hud, fade, lvl,
                      (n == count / 2) || ($urandom_range(0, 99) == 0));
      end
   endtask

   // sender: bursts of back-to-back requests separated by random gaps;
   // the payload only changes once the offered request has been taken
   always @(posedge clock) begin : req_driver
      pending_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0 &&
                      !(req_backlog[0].hold_off && (req_valid || levels_in_flight != 0))) begin
            nxt = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_opcode <= nxt.body.opcode;
            req_elapsed_ms <= nxt.body.elapsed_ms;
            req_want_visible <= nxt.body.want_visible;
            req_loading_now <= nxt.body.loading_now;
            req_hud_now <= nxt.body.hud_now;
            req_screen_fading <= nxt.body.screen_fading;
            req_force_level <= nxt.body.force_level;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 30);
               case ($urandom_range(0, 9))
                  0, 1, 2: gap_left = 0;
                  3: gap_left = $urandom_range(10, 25);
                  default: gap_left = $urandom_range(1, 8);
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: switches between stall patterns every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 150);
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
            RX_CHOKE: rsp_ready <= ($urandom_range(0, 4) == 0);
            default:  rsp_ready <= rx_left[2];
         endcase
      end
   end

   // scoreboard: check the returning level first, then predict the request
   // accepted at this edge, so the order of the two is fixed
   always @(posedge clock) begin : level_check
      ofe_item_type taken;
      logic [LevelWidth-1:0] want;
      if (reset) begin
         cfg_shadow.rise_rate = RiseRateReset;
         cfg_shadow.fall_rate = FallRateReset;
         cfg_shadow.settle_time = SettleTimeReset;
         cfg_shadow.hold_limit = HoldLimitReset;
         env_level = '0;
         env_hold = 16'd0;
         env_settle = 16'd0;
         env_was_loading = 1'b0;
         env_was_hud = 1'b0;
         levels_in_flight <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: level %0d returned with no request outstanding", $time, rsp_level);
               mismatch_count++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_level !== want) begin
                  $display("%0t: level mismatch, expected %0d, actual %0d",
                           $time, want, rsp_level);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            taken.opcode = req_opcode;
            taken.elapsed_ms = req_elapsed_ms;
            taken.want_visible = req_want_visible;
            taken.loading_now = req_loading_now;
            taken.hud_now = req_hud_now;
            taken.screen_fading = req_screen_fading;
            taken.force_level = req_force_level;
            expected_levels.push_back(advance_envelope(taken));
         end
         levels_in_flight <= levels_in_flight + int'(req_valid && req_ready)
                                              - int'(rsp_valid && rsp_ready);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed requests under the reset register values
      queue_req(OP_TICK, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
      // longest tick while visible saturates at full level
      queue_req(OP_TICK, 10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
      // force ignores the flags and the elapsed time
      queue_req(OP_FORCE, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1, LevelMax, 1'b0);
      // hud opening arms the hold and counts it down in the same tick
      queue_req(OP_TICK, 10'd10, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
      // screen fade keeps reloading the settle timer
      queue_req(OP_TICK, 10'd100, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd399, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
      // settle runs out, hold ends and the level rises again
      queue_req(OP_TICK, 10'd1, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
      queue_req(OpUnused, 10'($urandom_range(0, 1023)), 1'b1, 1'b1, 1'b0, 1'b1,
                16'($urandom_range(0, 65535)), 1'b0);
      queue_req(OP_RESET, 10'd500, 1'b1, 1'b0, 1'b0, 1'b0, LevelMax, 1'b0);
      queue_req(OP_FORCE, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd5, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0);
      // loading screen closes: hold armed
      queue_req(OP_TICK, 10'd5, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd5, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
      // force drops a running hold
      queue_req(OP_FORCE, 10'd0, 1'b0, 1'b1, 1'b0, 1'b1, 16'h8000, 1'b0);
      queue_req(OP_TICK, 10'd3, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd1000, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0);
      // loading closing and hud opening in one tick
      queue_req(OP_TICK, 10'd7, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0);
      queue_req(OP_RESET, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);

      // zero settle time: an armed hold ends on its first tick
      wait_for_idle();
      write_csr(CSR_SETTLE_TIME, 16'd0);
      queue_req(OP_TICK, 10'd2, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd4, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);

      // zero hold limit: an arming edge leaves no hold behind
      wait_for_idle();
      write_csr(CSR_SETTLE_TIME, SettleTimeReset);
      write_csr(CSR_HOLD_LIMIT, 16'd0);
      queue_req(OP_TICK, 10'd2, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0);
      queue_req(OP_TICK, 10'd4, 1'b1, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0);

      // random batches, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_envelope_config(16'd1, 16'd1, 16'd0, 16'd0);
            1: set_envelope_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_envelope_config(RiseRateReset, FallRateReset, SettleTimeReset,
                                   HoldLimitReset);
            3: set_envelope_config(16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
            4: set_envelope_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd0);
            default: set_envelope_config(16'($urandom_range(1, 2500)),
                                         16'($urandom_range(1, 2500)),
                                         16'($urandom_range(0, 600)),
                                         16'($urandom_range(0, 3000)));
         endcase
         queue_random_reqs(175);
      end

      // drain, then give the pipeline a few more cycles for stray levels
      wait_for_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0)
         $display("overlay_fade_envelope test passed");
      else
         $display("overlay_fade_envelope test failed");
      $finish;
   end

   initial begin
      #(RunLimitNs);
      $display("%0t: run did not finish in time", $time);
      $display("overlay_fade_envelope test failed");
      $finish;
   end

endmodule
